>>> rtl/chta_pkg.sv
// ----------------------------------------------------------------------------
// chta_pkg
// Shared types and constants for the clustered hash table with aging.
// ----------------------------------------------------------------------------
package chta_pkg;

    localparam int CLUSTERS_DEF = 16384;
    localparam int WAYS_DEF     = 3;

    localparam int          AGE_SHIFT    = 3;
    localparam logic [9:0]  DEPTH_MARGIN = 10'd4;
    localparam logic [4:0]  GEN_MASK     = 5'd31;

    localparam logic [1:0] MODE_PROBE   = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_PENALTY = 2'd2;
    localparam logic [1:0] MODE_ADVANCE = 2'd3;

    localparam logic [1:0] BOUND_EXACT = 2'd3;

    localparam logic [1:0] CFG_CLUSTER_COUNT  = 2'd0;
    localparam logic [1:0] CFG_DEPTH_OFFSET   = 2'd1;
    localparam logic [1:0] CFG_DECISIVE_FLOOR = 2'd2;
    localparam logic [1:0] CFG_VALUE_LIMIT    = 2'd3;

    localparam logic [14:0] CLUSTER_COUNT_RST  = 15'd16384;
    localparam logic [4:0]  DEPTH_OFFSET_RST   = 5'b11101;
    localparam logic [14:0] DECISIVE_FLOOR_RST = 15'd31507;
    localparam logic [14:0] VALUE_LIMIT_RST    = 15'd32001;

    typedef struct packed {
        logic [1:0]         mode;
        logic [63:0]        key;
        logic [1:0]         way;
        logic [15:0]        move;
        logic signed [15:0] score;
        logic signed [15:0] eval;
        logic [7:0]         depth;
        logic [1:0]         bound;
        logic               pv;
        logic [7:0]         penalty;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic [1:0]         slot;
        logic [15:0]        found_move;
        logic signed [15:0] found_score;
        logic signed [15:0] found_eval;
        logic [7:0]         found_depth;
        logic [1:0]         found_bound;
        logic               found_pv;
        logic [4:0]         current_generation;
    } out_item_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] move;
        logic [15:0] score;
        logic [15:0] eval;
        logic [7:0]  depth;
        logic [7:0]  meta;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/chta_ram.sv
// ----------------------------------------------------------------------------
// chta_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module chta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/clustered_hash_table_with_aging.sv
// ----------------------------------------------------------------------------
// clustered_hash_table_with_aging
// Clustered hash table with depth/age replacement and generation counter.
// ----------------------------------------------------------------------------
// After reset the block clears its cluster RAM one cluster per cycle and takes
// no item until that pass ends; configuration writes are taken at any time.
// Each item then runs through accept, key-by-cluster-count multiply in two
// 32-bit halves, cluster read, and decide-and-write-back before the next item
// is accepted, since one whole cluster row in the single cluster RAM is read,
// modified and written back. The result sits in an output register and the
// next item is taken while it waits; a later write-back waits until it is taken.
module clustered_hash_table_with_aging #(
    parameter int CLUSTERS = chta_pkg::CLUSTERS_DEF,
    parameter int WAYS     = chta_pkg::WAYS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  chta_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output chta_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [14:0]          cfg_data
);

    import chta_pkg::*;

    localparam int CW    = $clog2(CLUSTERS);
    localparam int WW    = $clog2(WAYS);
    localparam int ROW_W = WAYS * ENTRY_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ADDR  = 3'd3;
    localparam logic [2:0] ST_EXEC  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] clr_addr_reg, clr_addr_next;
    logic [4:0]    gen_reg, gen_next;
    logic [14:0]   cluster_count_reg;
    logic [4:0]    depth_offset_reg;
    logic [14:0]   decisive_floor_reg;
    logic [14:0]   value_limit_reg;
    logic          out_valid_reg, out_valid_next;

    in_item_t      item_reg;
    logic [46:0]   prod_lo_reg, prod_hi_reg;
    logic [CW-1:0] idx_reg;
    out_item_t     out_data_reg;

    logic [14:0]   cc_lim;
    logic [47:0]   idx_sum;
    logic [CW-1:0] idx_calc;
    logic          mem_we, mem_re;
    logic [CW-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata, rd_row;
    logic          exec_done;

    entry_t        ent     [WAYS];
    entry_t        new_ent [WAYS];
    logic          mt      [WAYS];
    logic signed [9:0] worth [WAYS];
    logic          hit;
    logic [WW-1:0] hway, best, tgt, wsel;
    logic          way_ok;
    entry_t        cur, upd;
    logic          same, lt, keep_dec;
    logic [4:0]    age_t;
    logic signed [9:0] dsum;
    logic [16:0]   mag;
    logic [15:0]   none_val;
    logic          write_row;
    out_item_t     res;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (32'(cluster_count_reg) > CLUSTERS)
        begin
            cc_lim = 15'(CLUSTERS);
        end
        else
        begin
            cc_lim = cluster_count_reg;
        end
    end

    assign idx_sum  = 48'(prod_hi_reg) + 48'(prod_lo_reg[46:32]);
    assign idx_calc = CW'(idx_sum[47:32]);

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            ent[i] = rd_row[i*ENTRY_W +: ENTRY_W];
        end
    end

    always_comb
    begin
        hit      = 1'b0;
        hway     = '0;
        best     = '0;
        tgt      = '0;
        wsel     = WW'(item_reg.way);
        way_ok   = 32'(item_reg.way) < WAYS;
        none_val = 16'(value_limit_reg) + 16'd1;
        gen_next = gen_reg;
        for (int i = 0; i < WAYS; i++)
        begin
            new_ent[i] = ent[i];
            mt[i]      = ent[i].tag == item_reg.key[15:0];
            worth[i]   = $signed({2'b00, ent[i].depth})
                       - $signed({2'b00, (gen_reg - ent[i].meta[4:0]) & GEN_MASK, 3'b000});
        end
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (mt[i])
            begin
                hit  = 1'b1;
                hway = WW'(i);
            end
        end
        for (int i = 1; i < WAYS; i++)
        begin
            if (worth[best] > worth[i])
            begin
                best = WW'(i);
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            if (i < int'(item_reg.way) && !mt[i])
            begin
                tgt = WW'(i + 1);
            end
        end

        cur      = ent[tgt];
        upd      = cur;
        same     = cur.tag == item_reg.key[15:0];
        age_t    = (gen_reg - cur.meta[4:0]) & GEN_MASK;
        lt       = {2'b00, cur.depth} < (DEPTH_MARGIN + {2'b00, item_reg.depth}
                   + {8'b0, item_reg.pv, 1'b0});
        dsum     = $signed({2'b00, cur.depth})
                 + $signed({{5{depth_offset_reg[4]}}, depth_offset_reg});
        mag      = cur.score[15] ? ({1'b0, ~cur.score} + 17'd1) : {1'b0, cur.score};
        keep_dec = (dsum > $signed(DEPTH_MARGIN)) && (cur.meta[6:5] != BOUND_EXACT)
                 && (mag < 17'(value_limit_reg)) && (mag >= 17'(decisive_floor_reg));
        if (!same || item_reg.move != 16'd0)
        begin
            upd.move = item_reg.move;
        end
        if (!same || item_reg.bound == BOUND_EXACT || lt || age_t != 5'd0)
        begin
            upd.tag   = item_reg.key[15:0];
            upd.score = item_reg.score;
            upd.eval  = item_reg.eval;
            upd.depth = item_reg.depth;
            upd.meta  = {item_reg.pv, item_reg.bound, gen_reg};
        end
        else if (keep_dec)
        begin
            upd.depth = (cur.depth == 8'd0) ? 8'd0 : cur.depth - 8'd1;
        end

        res                    = '0;
        write_row              = 1'b0;
        case (item_reg.mode)
            MODE_PROBE:
            begin
                if (hit)
                begin
                    res.hit         = 1'b1;
                    res.slot        = 2'(hway);
                    res.found_move  = ent[hway].move;
                    res.found_score = ent[hway].score;
                    res.found_eval  = ent[hway].eval;
                    res.found_depth = ent[hway].depth;
                    res.found_bound = ent[hway].meta[6:5];
                    res.found_pv    = ent[hway].meta[7];
                end
                else
                begin
                    res.slot        = 2'(best);
                    res.found_score = none_val;
                    res.found_eval  = none_val;
                end
            end
            MODE_WRITE:
            begin
                if (way_ok)
                begin
                    write_row = 1'b1;
                    for (int i = 0; i < WAYS; i++)
                    begin
                        if (i > int'(tgt) && i <= int'(item_reg.way))
                        begin
                            new_ent[i] = '0;
                        end
                    end
                    new_ent[tgt] = upd;
                end
            end
            MODE_PENALTY:
            begin
                if (way_ok)
                begin
                    write_row = 1'b1;
                    new_ent[wsel].depth = (ent[wsel].depth > item_reg.penalty)
                                        ? ent[wsel].depth - item_reg.penalty : 8'd0;
                end
            end
            default:
            begin
                gen_next = gen_reg + 5'd1;
            end
        endcase
        res.current_generation = gen_next;
    end

    assign exec_done = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        mem_re    = (state_reg == ST_ADDR);
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
        end
        else if (exec_done && write_row)
        begin
            mem_we = 1'b1;
            for (int i = 0; i < WAYS; i++)
            begin
                mem_wdata[i*ENTRY_W +: ENTRY_W] = new_ent[i];
            end
        end
    end

    chta_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CLUSTERS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_calc),
        .rdata (rd_row)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + CW'(1);
                if (clr_addr_reg == CW'(CLUSTERS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (exec_done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clr_addr_reg       <= '0;
            gen_reg            <= '0;
            out_valid_reg      <= 1'b0;
            cluster_count_reg  <= CLUSTER_COUNT_RST;
            depth_offset_reg   <= DEPTH_OFFSET_RST;
            decisive_floor_reg <= DECISIVE_FLOOR_RST;
            value_limit_reg    <= VALUE_LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (exec_done)
            begin
                gen_reg <= gen_next;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_CLUSTER_COUNT:  cluster_count_reg  <= cfg_data;
                    CFG_DEPTH_OFFSET:   depth_offset_reg   <= cfg_data[4:0];
                    CFG_DECISIVE_FLOOR: decisive_floor_reg <= cfg_data;
                    CFG_VALUE_LIMIT:    value_limit_reg    <= cfg_data;
                    default:            value_limit_reg    <= value_limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        if (state_reg == ST_MUL)
        begin
            prod_lo_reg <= 47'(item_reg.key[31:0]) * 47'(cc_lim);
            prod_hi_reg <= 47'(item_reg.key[63:32]) * 47'(cc_lim);
        end
        if (state_reg == ST_ADDR)
        begin
            idx_reg <= idx_calc;
        end
        if (exec_done)
        begin
            out_data_reg <= res;
        end
    end

endmodule

>>> rtl/chta_checker.sv
// ----------------------------------------------------------------------------
// chta_checker
// Port-level checks for the clustered hash table, bound to the top level.
// ----------------------------------------------------------------------------
module chta_checker #(
    parameter int WAYS = chta_pkg::WAYS_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input chta_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input chta_pkg::out_item_t out_data
);

    import chta_pkg::*;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.found_move == 16'd0
        && out_data.found_depth == 8'd0 && out_data.found_bound == 2'd0
        && out_data.found_pv == 1'b0)
        else $error("miss result carries entry fields");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(out_data.slot) < WAYS)
        else $error("slot beyond cluster ways");

endmodule

bind clustered_hash_table_with_aging chta_checker #(.WAYS(WAYS)) u_chta_checker (.*);
